// ----- hdl/fbb_pkg.sv -----
// ----------------------------------------------------------------------------
// fbb_pkg: shared types and constants of the free block bitmap unit
// Operation codes, controller states and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package fbb_pkg;

    localparam int MAX_BLOCKS_DEF = 4096;
    localparam int WORD_BITS      = 8;
    localparam int CNT_W          = 13;
    localparam int IDX_W          = 12;
    localparam int OP_W           = 3;

    localparam logic [CNT_W-1:0] COUNT_RESET = 13'd4096;

    localparam logic [OP_W-1:0] OP_SET       = 3'd0;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd1;
    localparam logic [OP_W-1:0] OP_TEST      = 3'd2;
    localparam logic [OP_W-1:0] OP_FIND      = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR_ALL = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RMW,
        ST_FIND,
        ST_CLR
    } t_state;

endpackage

`default_nettype wire

// ----- hdl/free_block_bitmap_unit.sv -----
// ----------------------------------------------------------------------------
// free_block_bitmap_unit: block allocation bitmap
// One bit per block in a byte-wide synchronous RAM; set, clear, test, find
// lowest free block and clear all.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with i_operation and i_block_index; the request is taken at a
//   clock edge where busy is low. Exactly one result follows, shown for one
//   cycle with o_result_valid; the receiver cannot stall it.
//   Steps from acceptance to the result strobe:
//     set / clear / test in range : RAM read, then modify and write back
//     out of range, unused code,
//     find with a zero count      : result registered without a RAM read
//     find                        : read word 0, then check one word per step,
//                                   stopping at the first free block or last word
//     clear all                   : write zero to each RAM word in turn
//   The single RAM port pair, one word per cycle, paces these steps.
//   block_count is written on the cfg channel (i_cfg_valid / o_cfg_ready);
//   the user must write it only while the unit is idle, as the unit does
//   not enforce this; it resets to 4096. After reset the unit sweeps every
//   RAM word to zero with busy high; no result is produced for that sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module free_block_bitmap_unit #(
    parameter int MAX_BLOCKS = fbb_pkg::MAX_BLOCKS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [fbb_pkg::OP_W-1:0]  i_operation,
    input  wire logic [fbb_pkg::IDX_W-1:0] i_block_index,
    output logic                           o_result_valid,
    output logic                           o_status,
    output logic                           o_bit_value,
    output logic                           o_found,
    output logic [fbb_pkg::IDX_W-1:0]      o_free_index,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [fbb_pkg::CNT_W-1:0] i_cfg_data
);
    import fbb_pkg::*;

    localparam int DEPTH = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = AW + 3;
    localparam int CW    = (IW + 1 > CNT_W) ? IW + 1 : CNT_W;

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] r_rdata;

    t_state            r_state, n_state;
    logic [OP_W-1:0]   r_op, n_op;
    logic [2:0]        r_bitpos, n_bitpos;
    logic [AW-1:0]     r_widx, n_widx;
    logic              r_init, n_init;
    logic [CNT_W-1:0]  r_block_count;
    logic              r_valid, n_valid;
    logic              r_status, n_status;
    logic              r_bit, n_bit;
    logic              r_found, n_found;
    logic [IDX_W-1:0]  r_idx, n_idx;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [AW-1:0]        mem_raddr;

    logic [CW-1:0]        cnt_ext;
    logic [CW-1:0]        eff_cnt;
    logic                 in_range;
    logic [CW-1:0]        base;
    logic [WORD_BITS-1:0] lane_ok;
    logic [WORD_BITS-1:0] cand;
    logic [2:0]           sel;
    logic                 last_word;
    logic [WORD_BITS-1:0] mask;

    // saturate the count at the map size
    assign cnt_ext  = CW'(r_block_count);
    assign eff_cnt  = (cnt_ext > CW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : cnt_ext;
    assign in_range = CW'(i_block_index) < eff_cnt;

    assign base      = CW'({r_widx, 3'b000});
    assign last_word = (base + CW'(WORD_BITS)) >= eff_cnt;
    assign mask      = WORD_BITS'(1) << r_bitpos;

    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            lane_ok[j] = (base + CW'(j)) < eff_cnt;
        end
        cand = ~r_rdata & lane_ok;
        sel  = 3'd0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (cand[j]) begin
                sel = 3'(j);
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_bitpos  = r_bitpos;
        n_widx    = r_widx;
        n_init    = r_init;
        n_valid   = 1'b0;
        n_status  = 1'b0;
        n_bit     = 1'b0;
        n_found   = 1'b0;
        n_idx     = '0;
        mem_we    = 1'b0;
        mem_waddr = r_widx;
        mem_wdata = '0;
        mem_raddr = r_widx;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_op     = i_operation;
                    n_bitpos = i_block_index[2:0];
                    if (i_operation == OP_SET || i_operation == OP_CLEAR ||
                        i_operation == OP_TEST) begin
                        mem_raddr = AW'(i_block_index >> 3);
                        n_widx    = AW'(i_block_index >> 3);
                        if (in_range) begin
                            n_state = ST_RMW;
                        end else begin
                            n_valid  = 1'b1;
                            n_status = 1'b1;
                        end
                    end else if (i_operation == OP_FIND) begin
                        mem_raddr = '0;
                        n_widx    = '0;
                        if (eff_cnt == '0) begin
                            n_valid = 1'b1;
                        end else begin
                            n_state = ST_FIND;
                        end
                    end else if (i_operation == OP_CLEAR_ALL) begin
                        n_widx  = '0;
                        n_init  = 1'b0;
                        n_state = ST_CLR;
                    end else begin
                        n_valid = 1'b1;
                    end
                end
            end
            ST_RMW: begin
                // modify the word read last cycle and write it back, or test its bit
                if (r_op == OP_SET) begin
                    mem_we    = 1'b1;
                    mem_wdata = r_rdata | mask;
                end else if (r_op == OP_CLEAR) begin
                    mem_we    = 1'b1;
                    mem_wdata = r_rdata & ~mask;
                end else begin
                    n_bit = |(r_rdata & mask);
                end
                n_valid = 1'b1;
                n_state = ST_IDLE;
            end
            ST_FIND: begin
                if (cand != '0) begin
                    n_valid = 1'b1;
                    n_found = 1'b1;
                    n_idx   = IDX_W'(base + CW'(sel));
                    n_state = ST_IDLE;
                end else if (last_word) begin
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    // advance to the next word
                    n_widx    = r_widx + AW'(1);
                    mem_raddr = r_widx + AW'(1);
                end
            end
            ST_CLR: begin
                mem_we = 1'b1;
                if (r_widx == AW'(DEPTH - 1)) begin
                    n_valid = !r_init;
                    n_init  = 1'b0;
                    n_state = ST_IDLE;
                end else begin
                    n_widx = r_widx + AW'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLR;
            r_widx        <= '0;
            r_init        <= 1'b1;
            r_valid       <= 1'b0;
            r_block_count <= COUNT_RESET;
        end else begin
            r_state <= n_state;
            r_widx  <= n_widx;
            r_init  <= n_init;
            r_valid <= n_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_block_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_bitpos <= n_bitpos;
        r_status <= n_status;
        r_bit    <= n_bit;
        r_found  <= n_found;
        r_idx    <= n_idx;
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_result_valid = r_valid;
    assign o_status       = r_status;
    assign o_bit_value    = r_bit;
    assign o_found        = r_found;
    assign o_free_index   = r_idx;

`ifndef SYNTHESIS
    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result strobe while a request is still in progress");

    a_request_progresses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_result_valid))
        else $error("accepted request neither busy nor answered");

    a_found_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_found) |-> (!o_status && !o_bit_value))
        else $error("find result carries status or bit value");

    a_found_below_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIND && n_found) |-> (CW'(n_idx) < eff_cnt || CW > IDX_W))
        else $error("find returned an index at or above the count");
`endif

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for free_block_bitmap_unit
// Drives set, clear, test, find, clear-all and unused-code requests in
// bursts with random gaps, mirrors the allocation map and block count in
// a local model, checks every result strobe against the oldest prediction.
// ----------------------------------------------------------------------------

module testbench;

    import fbb_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    localparam int RANDOM_ITEMS   = 1650;
    localparam int N_PHASES       = 12;
    localparam int QUIET_LIMIT    = 4000;
    localparam int LINGER_CYCLES  = 600;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic             status;
        logic             bit_value;
        logic             found;
        logic [IDX_W-1:0] free_index;
    } t_result;

    typedef struct packed {
        bit               cfg;
        logic [CNT_W-1:0] cfg_value;
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] idx;
        bit               typed;
        t_result          exp;
    } t_row;

    localparam t_result R_ZERO  = '0;
    localparam t_result R_RANGE = '{1'b1, 1'b0, 1'b0, 12'd0};
    localparam t_result R_BIT   = '{1'b0, 1'b1, 1'b0, 12'd0};
    localparam t_result R_FREE0 = '{1'b0, 1'b0, 1'b1, 12'd0};
    localparam t_result R_FREE1 = '{1'b0, 1'b0, 1'b1, 12'd1};

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [OP_W-1:0]  i_operation = OP_TEST;
    logic [IDX_W-1:0] i_block_index = '0;
    logic             o_result_valid;
    logic             o_status;
    logic             o_bit_value;
    logic             o_found;
    logic [IDX_W-1:0] o_free_index;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CNT_W-1:0] i_cfg_data = COUNT_RESET;

    // typed expectation travels with the request it belongs to
    logic             hold_typed = 1'b0;
    t_result          hold_exp = '0;

    logic [MAX_BLOCKS_DEF-1:0] alloc_map = '0;
    logic [CNT_W-1:0]          block_count = COUNT_RESET;
    t_result                   expected_results [$];
    int                        failures = 0;
    int                        quiet_cycles = 0;
    int                        burst_left = 0;
    int                        sent = 0;

    free_block_bitmap_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_block_index  (i_block_index),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_bit_value    (o_bit_value),
        .o_found        (o_found),
        .o_free_index   (o_free_index),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic int eff_count();
        return (block_count > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : int'(block_count);
    endfunction

    function automatic int next_free(input int from);
        int lim;
        lim = eff_count();
        for (int b = from; b < lim; b++)
            if (!alloc_map[b]) return b;
        return -1;
    endfunction

    function automatic t_result predict_request(input logic [OP_W-1:0] op,
                                                input logic [IDX_W-1:0] idx);
        t_result r;
        int      lim;
        int      hit;
        r = '0;
        lim = eff_count();
        case (op)
            OP_SET, OP_CLEAR, OP_TEST: begin
                if (int'(idx) >= lim) r.status = 1'b1;
                else if (op == OP_SET) alloc_map[idx] = 1'b1;
                else if (op == OP_CLEAR) alloc_map[idx] = 1'b0;
                else r.bit_value = alloc_map[idx];
            end
            OP_FIND: begin
                hit = next_free(0);
                if (hit >= 0) begin
                    r.found = 1'b1;
                    r.free_index = IDX_W'(hit);
                end
            end
            OP_CLEAR_ALL: alloc_map = '0;
            default: ;
        endcase
        return r;
    endfunction

    task automatic note_failure(input string what);
        failures++;
        if (failures <= REPORT_LIMIT) $display("[%0t] %s", $time, what);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        bit      moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (o_result_valid) begin
                moved = 1'b1;
                got = '{o_status, o_bit_value, o_found, o_free_index};
                if (expected_results.size() == 0) begin
                    note_failure($sformatf("result with no request outstanding: %p", got));
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status || got.bit_value !== want.bit_value ||
                        got.found !== want.found || got.free_index !== want.free_index)
                        note_failure($sformatf("result mismatch: expected %p, got %p",
                                               want, got));
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
                block_count = i_cfg_data;
            end
            if (start && !busy) begin
                moved = 1'b1;
                want = predict_request(i_operation, i_block_index);
                expected_results.push_back(hold_typed ? hold_exp : want);
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Hold start high until a clock edge finds busy low; gaps open between bursts.
    task automatic issue(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                         input bit typed, input t_result exp);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        start         <= 1'b1;
        i_operation   <= op;
        i_block_index <= idx;
        hold_typed    <= typed;
        hold_exp      <= exp;
        do @(posedge i_clk); while (busy);
        sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CNT_W-1:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [IDX_W-1:0] pick_index(input int lim);
        int r;
        int near;
        r = $urandom_range(0, 9);
        if (lim == 0 || r < 2) return IDX_W'($urandom_range(0, MAX_BLOCKS_DEF - 1));
        if (r < 4) begin
            near = lim - 2 + $urandom_range(0, 3);
            if (near < 0) near = 0;
            if (near > MAX_BLOCKS_DEF - 1) near = MAX_BLOCKS_DEF - 1;
            return IDX_W'(near);
        end
        return IDX_W'($urandom_range(0, lim - 1));
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return OP_SET;
        if (r < 48) return OP_CLEAR;
        if (r < 68) return OP_TEST;
        if (r < 90) return OP_FIND;
        if (r < 93) return OP_CLEAR_ALL;
        return OP_W'($urandom_range(OP_SPARE_5, OP_SPARE_7));
    endfunction

    initial begin : stimulus
        t_row             script [$];
        logic [CNT_W-1:0] phase_counts [N_PHASES];
        logic [IDX_W-1:0] idx;
        int               lim;
        int               mark;
        int               kind;
        int               spot;

        script = '{
            '{1'b0, 13'd0,    OP_TEST,      12'd0,    1'b1, R_ZERO},
            '{1'b0, 13'd0,    OP_TEST,      12'd4095, 1'b1, R_ZERO},
            '{1'b0, 13'd0,    OP_FIND,      12'd0,    1'b1, R_FREE0},
            '{1'b0, 13'd0,    OP_SET,       12'd0,    1'b1, R_ZERO},
            '{1'b0, 13'd0,    OP_SET,       12'd4095, 1'b1, R_ZERO},
            '{1'b0, 13'd0,    OP_TEST,      12'd4095, 1'b1, R_BIT},
            '{1'b0, 13'd0,    OP_FIND,      12'd4095, 1'b1, R_FREE1},
            '{1'b0, 13'd0,    OP_CLEAR,     12'd0,    1'b1, R_ZERO},
            '{1'b0, 13'd0,    OP_FIND,      12'd0,    1'b1, R_FREE0},
            '{1'b0, 13'd0,    OP_SET,       12'hAAA,  1'b0, R_ZERO},
            '{1'b0, 13'd0,    OP_TEST,      12'hAAA,  1'b0, R_ZERO},
            '{1'b0, 13'd0,    OP_SET,       12'h555,  1'b0, R_ZERO},
            '{1'b0, 13'd0,    OP_CLEAR,     12'd4095, 1'b0, R_ZERO},
            '{1'b0, 13'd0,    OP_SPARE_5,   12'd4095, 1'b1, R_ZERO},
            '{1'b0, 13'd0,    OP_SPARE_6,   12'h555,  1'b1, R_ZERO},
            '{1'b0, 13'd0,    OP_SPARE_7,   12'd0,    1'b1, R_ZERO},
            '{1'b0, 13'd0,    OP_CLEAR_ALL, 12'd0,    1'b1, R_ZERO},
            '{1'b0, 13'd0,    OP_TEST,      12'hAAA,  1'b1, R_ZERO},
            // partial final word: ten blocks
            '{1'b1, 13'd10,   OP_TEST,      12'd0,    1'b0, R_ZERO},
            '{1'b0, 13'd0,    OP_TEST,      12'd10,   1'b1, R_RANGE},
            '{1'b0, 13'd0,    OP_SET,       12'd9,    1'b1, R_ZERO},
            '{1'b0, 13'd0,    OP_FIND,      12'd0,    1'b0, R_ZERO},
            // zero count: nothing in range, nothing to find
            '{1'b1, 13'd0,    OP_TEST,      12'd0,    1'b0, R_ZERO},
            '{1'b0, 13'd0,    OP_TEST,      12'd0,    1'b1, R_RANGE},
            '{1'b0, 13'd0,    OP_FIND,      12'd0,    1'b1, R_ZERO},
            // count past the map saturates
            '{1'b1, 13'd8191, OP_TEST,      12'd0,    1'b0, R_ZERO},
            '{1'b0, 13'd0,    OP_SET,       12'd4095, 1'b0, R_ZERO},
            // single block: fill it, then the map is full
            '{1'b1, 13'd1,    OP_TEST,      12'd0,    1'b0, R_ZERO},
            '{1'b0, 13'd0,    OP_SET,       12'd0,    1'b1, R_ZERO},
            '{1'b0, 13'd0,    OP_FIND,      12'd0,    1'b1, R_ZERO},
            '{1'b0, 13'd0,    OP_CLEAR,     12'd4095, 1'b1, R_RANGE}
        };

        phase_counts = '{13'd7, 13'd8, 13'd9, 13'd13, 13'd1, 13'd64, 13'd0, 13'd8191,
                         CNT_W'($urandom_range(1, 200)), CNT_W'($urandom_range(200, 4096)),
                         13'd4096, CNT_W'($urandom_range(4097, 8191))};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            if (script[i].cfg) cfg_write(script[i].cfg_value);
            else issue(script[i].op, script[i].idx, script[i].typed, script[i].exp);
        end

        foreach (phase_counts[p]) begin
            cfg_write(phase_counts[p]);
            lim = (phase_counts[p] > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : int'(phase_counts[p]);
            mark = sent;
            while (sent - mark < RANDOM_ITEMS / N_PHASES) begin
                kind = $urandom_range(0, 9);
                if (kind < 5) begin
                    // allocate: find the lowest free block, then claim it
                    drain();
                    spot = next_free(0);
                    repeat ($urandom_range(1, 12)) begin
                        issue(OP_FIND, pick_index(lim), 1'b0, R_ZERO);
                        if (spot >= 0) begin
                            issue(OP_SET, IDX_W'(spot), 1'b0, R_ZERO);
                            spot = next_free(spot + 1);
                        end else begin
                            issue(OP_TEST, pick_index(lim), 1'b0, R_ZERO);
                        end
                    end
                end else if (kind == 5) begin
                    // release: free a block and read it back
                    repeat ($urandom_range(1, 6)) begin
                        idx = (lim == 0) ? pick_index(lim) : IDX_W'($urandom_range(0, lim - 1));
                        issue(OP_CLEAR, idx, 1'b0, R_ZERO);
                        issue(OP_TEST, idx, 1'b0, R_ZERO);
                    end
                end else begin
                    repeat ($urandom_range(1, 16))
                        issue(pick_op(), pick_index(lim), 1'b0, R_ZERO);
                end
            end
        end

        drain();
        repeat (LINGER_CYCLES) @(posedge i_clk);
        if (failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/fbb_pkg.sv
hdl/free_block_bitmap_unit.sv
tb/testbench.sv
